>>> rtl/ildb_pkg.sv
// Package for the interrupt line lockout debounce block.
// Holds widths, request and status codes, and the controller/datapath link types.
// No dependencies.
`default_nettype none

package ildb_pkg;

	localparam int LINES           = 16;
	localparam int LINE_W          = 4;
	localparam int TIME_W          = 32;
	localparam int DEFAULT_LOCK_MS = 200;

	typedef logic [LINE_W-1:0] line_t;
	typedef logic [TIME_W-1:0] ms_t;

	typedef enum logic [1:0] {
		FUNC_TICK   = 2'd0,
		FUNC_EVENT  = 2'd1,
		FUNC_PERIOD = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_FIRED      = 2'd0,
		ST_LOCKED     = 2'd1,
		ST_UNLOCKED   = 2'd2,
		ST_NO_HANDLER = 2'd3
	} status_t;

	typedef enum logic {
		CTL_IDLE = 1'b0,
		CTL_EXEC = 1'b1
	} ctl_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load_req;
		logic exec;
	} ildb_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_event;
	} ildb_stat_t;

endpackage

`default_nettype wire

>>> rtl/ildb_datapath.sv
// Datapath: request register, millisecond clock, per-line lock state and periods,
// handler mask and the result register. Uses ildb_pkg.
`default_nettype none

module ildb_datapath (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire ildb_pkg::ildb_cmd_t     cmd,
	output ildb_pkg::ildb_stat_t         stat,
	input  wire logic [1:0]              func,
	input  wire logic [ildb_pkg::LINE_W-1:0] line,
	input  wire logic [ildb_pkg::TIME_W-1:0] period_value,
	input  wire logic                    cfg_we,
	input  wire logic [ildb_pkg::LINES-1:0] cfg_wdata,
	output logic [ildb_pkg::LINE_W-1:0]  event_line,
	output logic [1:0]                   status
);

	ildb_pkg::func_t  func_q;
	ildb_pkg::line_t  line_q;
	ildb_pkg::ms_t    period_q;
	ildb_pkg::ms_t    now_q;
	logic [ildb_pkg::LINES-1:0] mask_q;
	logic [ildb_pkg::LINES-1:0] locked_q;
	ildb_pkg::ms_t    start_q  [ildb_pkg::LINES];
	ildb_pkg::ms_t    lperiod_q [ildb_pkg::LINES];
	ildb_pkg::line_t  event_line_q;
	ildb_pkg::status_t status_q;

	ildb_pkg::ms_t     elapsed;
	logic              expired;
	ildb_pkg::status_t st_next;

	always_comb begin
		elapsed = now_q - start_q[line_q];
		expired = elapsed > lperiod_q[line_q];
		if (locked_q[line_q]) begin
			st_next = expired ? ildb_pkg::ST_UNLOCKED : ildb_pkg::ST_LOCKED;
		end else if (mask_q[line_q]) begin
			st_next = ildb_pkg::ST_FIRED;
		end else begin
			st_next = ildb_pkg::ST_NO_HANDLER;
		end
	end

	assign stat.is_event = (func_q == ildb_pkg::FUNC_EVENT);

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			func_q   <= ildb_pkg::func_t'(func);
			line_q   <= line;
			period_q <= period_value;
		end
		if (cmd.exec && func_q == ildb_pkg::FUNC_EVENT) begin
			event_line_q <= line_q;
			status_q     <= st_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q    <= '0;
			mask_q   <= '0;
			locked_q <= '0;
			for (int i = 0; i < ildb_pkg::LINES; i++) begin
				start_q[i]   <= '0;
				lperiod_q[i] <= ildb_pkg::ms_t'(ildb_pkg::DEFAULT_LOCK_MS);
			end
		end else begin
			if (cfg_we) begin
				mask_q <= cfg_wdata;
			end
			if (cmd.exec) begin
				unique case (func_q)
					ildb_pkg::FUNC_TICK: begin
						now_q <= now_q + 1'b1;
					end
					ildb_pkg::FUNC_PERIOD: begin
						lperiod_q[line_q] <= period_q;
					end
					ildb_pkg::FUNC_EVENT: begin
						if (st_next == ildb_pkg::ST_FIRED) begin
							locked_q[line_q] <= 1'b1;
							start_q[line_q]  <= now_q;
						end else if (st_next == ildb_pkg::ST_UNLOCKED) begin
							locked_q[line_q] <= 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign event_line = event_line_q;
	assign status     = status_q;

endmodule

`default_nettype wire

>>> rtl/ildb_ctrl.sv
// Controller: takes one request, runs it through the datapath, and owns
// the result valid flag. Uses ildb_pkg.
`default_nettype none

module ildb_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	input  wire ildb_pkg::ildb_stat_t stat,
	output ildb_pkg::ildb_cmd_t       cmd
);

	ildb_pkg::ctl_state_t state_q, state_d;
	logic out_valid_q, out_valid_d;
	logic slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ildb_pkg::CTL_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd.load_req = 1'b0;
		cmd.exec     = 1'b0;
		in_ready     = 1'b0;
		out_valid_d  = out_valid_q && !out_ready;
		unique case (state_q)
			ildb_pkg::CTL_IDLE: begin
				in_ready     = 1'b1;
				cmd.load_req = in_valid;
				if (in_valid) begin
					state_d = ildb_pkg::CTL_EXEC;
				end
			end
			ildb_pkg::CTL_EXEC: begin
				// an event waits until the result register can take its result
				if (!stat.is_event || slot_free) begin
					cmd.exec = 1'b1;
					state_d  = ildb_pkg::CTL_IDLE;
					if (stat.is_event) begin
						out_valid_d = 1'b1;
					end
				end
			end
			default: begin
				state_d = ildb_pkg::CTL_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

>>> rtl/interrupt_line_lockout_debounce.sv
// Top level of the interrupt line lockout debounce block.
// Instantiates ildb_ctrl and ildb_datapath; uses ildb_pkg.
`default_nettype none

// Each request is first registered; then the line's lock state is looked up,
// the elapsed time compared with its period and the state updated.
// The two-state controller takes no new request until the last has executed.
// Interrupt events produce one result, held in an output register, so a new
// request is taken while a result waits; an event stalls in its execute state
// only if the previous result has still not been taken. Ticks, period writes
// and unused codes produce no result. The user must write the handler mask
// through cfg_we/cfg_wdata while the block is idle; the block does not enforce it.

module interrupt_line_lockout_debounce (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [1:0]                  func,
	input  wire logic [ildb_pkg::LINE_W-1:0] line,
	input  wire logic [ildb_pkg::TIME_W-1:0] period_value,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [ildb_pkg::LINE_W-1:0]      event_line,
	output logic [1:0]                       status,
	input  wire logic                        cfg_we,
	input  wire logic [ildb_pkg::LINES-1:0]  cfg_wdata
);

	ildb_pkg::ildb_cmd_t  cmd;
	ildb_pkg::ildb_stat_t stat;

	ildb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ildb_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.func         (func),
		.line         (line),
		.period_value (period_value),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.event_line   (event_line),
		.status       (status)
	);

endmodule

`default_nettype wire

>>> tb/sv/interrupt_line_lockout_debounce_tb.sv
// Testbench for interrupt_line_lockout_debounce: directed and random requests, with
// a scoreboard that models the per-line lockout gate. Depends on ildb_pkg and the RTL.
`timescale 1ns / 100ps

module interrupt_line_lockout_debounce_tb;

	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;

	typedef logic [ildb_pkg::LINES-1:0] mask_t;

	typedef struct {
		ildb_pkg::line_t   ln;
		ildb_pkg::status_t st;
	} verdict_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [1:0]           func = ildb_pkg::FUNC_TICK;
	ildb_pkg::line_t      line = '0;
	ildb_pkg::ms_t        period_value = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	ildb_pkg::line_t      event_line;
	logic [1:0]           status;
	logic                 cfg_we = 1'b0;
	mask_t                cfg_wdata = '0;

	// gate model state
	mask_t                handler_mask = '0;
	ildb_pkg::ms_t        clock_ms = '0;
	mask_t                line_locked = '0;
	ildb_pkg::ms_t        locked_at [ildb_pkg::LINES];
	ildb_pkg::ms_t        line_period [ildb_pkg::LINES];
	verdict_t             pending_verdicts[$];

	int                   send_idle_pct = 0;
	int                   take_idle_pct = 0;
	bit                   hold_req = 1'b0;
	int                   hold_cnt = 0;
	int                   stall_cycles = 0;
	int                   mismatches = 0;
	int                   req_count = 0;
	int                   status_seen [4];
	int                   mask_writes = 0;

	interrupt_line_lockout_debounce uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.line         (line),
		.period_value (period_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_line   (event_line),
		.status       (status),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < ildb_pkg::LINES; i++) begin
			locked_at[i] = '0;
			line_period[i] = ildb_pkg::ms_t'(ildb_pkg::DEFAULT_LOCK_MS);
		end
		for (int i = 0; i < 4; i++) status_seen[i] = 0;
	end

	function automatic void predict_gate(ildb_pkg::func_t f, ildb_pkg::line_t ln,
		ildb_pkg::ms_t pv);
		verdict_t v;
		req_count++;
		case (f)
			ildb_pkg::FUNC_TICK: clock_ms = clock_ms + 1;
			ildb_pkg::FUNC_PERIOD: line_period[ln] = pv;
			ildb_pkg::FUNC_EVENT: begin
				v.ln = ln;
				if (line_locked[ln]) begin
					// elapsed time wraps like the hardware counter
					if (ildb_pkg::ms_t'(clock_ms - locked_at[ln]) > line_period[ln]) begin
						line_locked[ln] = 1'b0;
						v.st = ildb_pkg::ST_UNLOCKED;
					end else begin
						v.st = ildb_pkg::ST_LOCKED;
					end
				end else if (handler_mask[ln]) begin
					locked_at[ln] = clock_ms;
					line_locked[ln] = 1'b1;
					v.st = ildb_pkg::ST_FIRED;
				end else begin
					v.st = ildb_pkg::ST_NO_HANDLER;
				end
				pending_verdicts.push_back(v);
			end
			default: ;
		endcase
	endfunction

	function automatic void check_verdict(ildb_pkg::line_t got_ln, ildb_pkg::status_t got_st);
		verdict_t v;
		if (pending_verdicts.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected result line %0d status %s", $realtime, got_ln,
					got_st.name());
			return;
		end
		v = pending_verdicts.pop_front();
		status_seen[got_st]++;
		if (got_ln !== v.ln || got_st !== v.st) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: mismatch: expected line %0d %s, got line %0d %s", $realtime,
					v.ln, v.st.name(), got_ln, got_st.name());
		end
	endfunction

	// Handshakes are judged at the falling edge; inputs only move at the rising edge.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				predict_gate(ildb_pkg::func_t'(func), line, period_value);
			if (out_valid && out_ready)
				check_verdict(event_line, ildb_pkg::status_t'(status));
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Watchdog: no progress for %0d cycles", STALL_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// result side, with a long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_cnt = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= take_idle_pct);
			end
		end
	end

	// Called and returns at a rising edge; leaves valid high so back-to-back
	// requests keep it up.
	task automatic send_req(ildb_pkg::func_t f, ildb_pkg::line_t ln, ildb_pkg::ms_t pv);
		bit taken;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		line <= ln;
		period_value <= pv;
		do begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		// ticks and period writes leave no result; let them finish
		repeat (4) @(posedge clk);
	endtask

	task automatic write_handler_mask(mask_t m);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		handler_mask = m;
		mask_writes++;
	endtask

	task automatic test_after_reset();
		send_req(ildb_pkg::FUNC_EVENT, 4'd0, '0);
		send_req(ildb_pkg::FUNC_EVENT, 4'd15, '1);
		send_req(ildb_pkg::FUNC_NONE, 4'd15, '1);
		send_req(ildb_pkg::FUNC_EVENT, 4'd7, '0);
	endtask

	task automatic test_fire_and_release();
		write_handler_mask('1);
		// zero period: held for the same ms, released one ms later
		send_req(ildb_pkg::FUNC_PERIOD, 4'd5, '0);
		send_req(ildb_pkg::FUNC_EVENT, 4'd5, '0);
		send_req(ildb_pkg::FUNC_EVENT, 4'd5, '0);
		send_req(ildb_pkg::FUNC_TICK, 4'd5, '1);
		send_req(ildb_pkg::FUNC_EVENT, 4'd5, '0);
		send_req(ildb_pkg::FUNC_EVENT, 4'd5, '0);
		// maximum period never runs out
		send_req(ildb_pkg::FUNC_PERIOD, 4'd6, '1);
		send_req(ildb_pkg::FUNC_EVENT, 4'd6, '0);
		repeat (3) send_req(ildb_pkg::FUNC_TICK, 4'd0, '0);
		send_req(ildb_pkg::FUNC_EVENT, 4'd6, '0);
		// default period on the top line
		send_req(ildb_pkg::FUNC_EVENT, 4'd15, '0);
		send_req(ildb_pkg::FUNC_EVENT, 4'd15, '0);
	endtask

	task automatic test_handler_removed();
		// line 5 is locked with period 0; the lock still expires without a handler
		write_handler_mask('0);
		send_req(ildb_pkg::FUNC_TICK, 4'd0, '0);
		send_req(ildb_pkg::FUNC_EVENT, 4'd5, '0);
		send_req(ildb_pkg::FUNC_EVENT, 4'd5, '0);
		send_req(ildb_pkg::FUNC_NONE, 4'd5, 32'h0000_0000);
	endtask

	task automatic send_random_req();
		ildb_pkg::func_t f;
		ildb_pkg::line_t ln;
		ildb_pkg::ms_t   pv;
		int    r;
		r = $urandom_range(99);
		if (r < 35) f = ildb_pkg::FUNC_TICK;
		else if (r < 75) f = ildb_pkg::FUNC_EVENT;
		else if (r < 95) f = ildb_pkg::FUNC_PERIOD;
		else f = ildb_pkg::FUNC_NONE;
		// crowd a few lines so locks interact
		ln = $urandom_range(1) ? ildb_pkg::line_t'($urandom_range(3)) :
			ildb_pkg::line_t'($urandom_range(15));
		r = $urandom_range(9);
		if (r < 6) pv = $urandom_range(15);
		else if (r < 8) pv = $urandom_range(300);
		else if (r == 8) pv = '1;
		else pv = $urandom();
		send_req(f, ln, pv);
	endtask

	task automatic test_random_phase(int snd_pct, int tak_pct, int n);
		mask_t m;
		send_idle_pct = snd_pct;
		take_idle_pct = tak_pct;
		for (int i = 0; i < n; i++) begin
			if (i % 150 == 0) begin
				case ($urandom_range(4))
					0: m = '0;
					1: m = '1;
					2: m = mask_t'($urandom());
					3: m = mask_t'(1) << $urandom_range(15);
					default: m = ~(mask_t'(1) << $urandom_range(15));
				endcase
				write_handler_mask(m);
			end
			send_random_req();
		end
	endtask

	task automatic test_backpressure();
		write_handler_mask('1);
		send_idle_pct = 0;
		hold_req = 1'b1;
		for (int i = 0; i < 40; i++)
			send_req(ildb_pkg::FUNC_EVENT, ildb_pkg::line_t'($urandom_range(15)), $urandom());
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 23;
		take_idle_pct = 68;
		test_after_reset();
		test_fire_and_release();
		test_handler_removed();
		test_random_phase(23, 68, 620);
		test_random_phase(68, 23, 620);
		test_backpressure();
		test_random_phase(0, 0, 610);
		drain_results();
		repeat (6) @(posedge clk);
		$display("Ran %0d requests over %0d mask settings, clock reached %0d ms", req_count,
			mask_writes, clock_ms);
		$display("Results: fired %0d, held %0d, released %0d, no handler %0d",
			status_seen[ildb_pkg::ST_FIRED], status_seen[ildb_pkg::ST_LOCKED],
			status_seen[ildb_pkg::ST_UNLOCKED], status_seen[ildb_pkg::ST_NO_HANDLER]);
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
